@@ src/grid_density_splat_counter_assert.svh @@
// Assertion helpers for the RTL (used in gdsc_back); each expects clk and rst_n in scope.
`ifndef GRID_DENSITY_SPLAT_COUNTER_ASSERT_SVH
`define GRID_DENSITY_SPLAT_COUNTER_ASSERT_SVH

// same-cycle implication
`define GDSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/gdsc_pkg.sv @@
`default_nettype none
package gdsc_pkg;

  // default sizing
  localparam int GRID_MAX_DEF   = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  // fixed field widths
  localparam int COORD_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SIZE_REG_W = 7;
  localparam int RD_IDX_W   = 6;
  localparam int OUT_CNT_W  = 16;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPU_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPU_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;

  // configuration register file
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0]        bins_per_unit_x;
    logic [COORD_W-1:0]        bins_per_unit_y;
    logic [SIZE_REG_W-1:0]     grid_width;
    logic [SIZE_REG_W-1:0]     grid_height;
  } cfg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SUB,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RD,
    B_WR,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

@@ src/gdsc_ram.sv @@
`default_nettype none
module gdsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ src/gdsc_fifo.sv @@
`default_nettype none
module gdsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gdsc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

@@ src/gdsc_front.sv @@
`default_nettype none
module gdsc_front #(
  parameter int GRID_MAX = gdsc_pkg::GRID_MAX_DEF,
  parameter int IDX_W    = $clog2(GRID_MAX),
  parameter int ENT_W    = 4 + 2 * IDX_W + 2 * gdsc_pkg::RD_IDX_W
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire gdsc_pkg::cfg_t                       cfg,
  input  wire logic                                 accept,
  input  wire logic                                 in_command,
  input  wire logic signed [gdsc_pkg::COORD_W-1:0]  in_point_x,
  input  wire logic signed [gdsc_pkg::COORD_W-1:0]  in_point_y,
  input  wire logic [gdsc_pkg::RD_IDX_W-1:0]        in_read_col,
  input  wire logic [gdsc_pkg::RD_IDX_W-1:0]        in_read_row,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output logic [ENT_W-1:0]                          q_data,
  output logic                                      front_busy
);

  localparam int SZ_W = IDX_W + 1;
  localparam int CW   = gdsc_pkg::COORD_W;

  gdsc_pkg::front_state_t state_r, state_nxt;

  logic                          cmd_r;
  logic signed [CW-1:0]          px_r, py_r;
  logic [gdsc_pkg::RD_IDX_W-1:0] rc_r, rr_r;
  logic signed [CW:0]            dx_r, dy_r;
  logic [CW-1:0]                 wx_r, wy_r;

  logic [2*CW-1:0]  prod_x, prod_y;
  logic [SZ_W-1:0]  size_x, size_y;
  logic [IDX_W-1:0] col, row;
  logic             right, up, oob;

  // active grid size: zero acts as one, capped at the store size
  always_comb begin
    if (cfg.grid_width == '0) begin
      size_x = SZ_W'(1);
    end else if (32'(cfg.grid_width) > 32'(GRID_MAX)) begin
      size_x = SZ_W'(GRID_MAX);
    end else begin
      size_x = SZ_W'(cfg.grid_width);
    end
    if (cfg.grid_height == '0) begin
      size_y = SZ_W'(1);
    end else if (32'(cfg.grid_height) > 32'(GRID_MAX)) begin
      size_y = SZ_W'(GRID_MAX);
    end else begin
      size_y = SZ_W'(cfg.grid_height);
    end
  end

  // offset times reciprocal, positive offsets only
  assign prod_x = 64'(dx_r[CW-1:0]) * 64'(cfg.bins_per_unit_x);
  assign prod_y = 64'(dy_r[CW-1:0]) * 64'(cfg.bins_per_unit_y);

  // clamp and edge flags
  always_comb begin
    if (wx_r >= CW'(size_x)) begin
      col = IDX_W'(size_x - SZ_W'(1));
    end else begin
      col = IDX_W'(wx_r);
    end
    if (wy_r >= CW'(size_y)) begin
      row = IDX_W'(size_y - SZ_W'(1));
    end else begin
      row = IDX_W'(wy_r);
    end
    right = (SZ_W'(col) + SZ_W'(1)) < size_x;
    up    = (SZ_W'(row) + SZ_W'(1)) < size_y;
    oob   = (32'(rc_r) >= 32'(GRID_MAX)) || (32'(rr_r) >= 32'(GRID_MAX));
  end

  // queue entry: {cmd, oob, right, up, col, row, out_col, out_row}
  always_comb begin
    if (cmd_r == gdsc_pkg::CMD_READ) begin
      q_data = {cmd_r, oob, 1'b0, 1'b0, IDX_W'(rc_r), IDX_W'(rr_r), rc_r, rr_r};
    end else begin
      q_data = {cmd_r, 1'b0, right, up, col, row,
                gdsc_pkg::RD_IDX_W'(col), gdsc_pkg::RD_IDX_W'(row)};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdsc_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == gdsc_pkg::CMD_READ) ? gdsc_pkg::F_PUSH
                                                          : gdsc_pkg::F_SUB;
        end
      end
      gdsc_pkg::F_SUB:  state_nxt = gdsc_pkg::F_MUL;
      gdsc_pkg::F_MUL:  state_nxt = gdsc_pkg::F_PUSH;
      gdsc_pkg::F_PUSH: begin
        if (!q_full) begin
          state_nxt = gdsc_pkg::F_IDLE;
        end
      end
      default: state_nxt = gdsc_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    front_busy = (state_r != gdsc_pkg::F_IDLE);
    q_push     = (state_r == gdsc_pkg::F_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdsc_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == gdsc_pkg::F_IDLE && accept) begin
      cmd_r <= in_command;
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      rc_r  <= in_read_col;
      rr_r  <= in_read_row;
    end
    if (state_r == gdsc_pkg::F_SUB) begin
      dx_r <= $signed({px_r[CW-1], px_r}) - $signed({cfg.origin_x[CW-1], cfg.origin_x});
      dy_r <= $signed({py_r[CW-1], py_r}) - $signed({cfg.origin_y[CW-1], cfg.origin_y});
    end
    if (state_r == gdsc_pkg::F_MUL) begin
      wx_r <= (dx_r[CW] || dx_r == '0) ? '0 : prod_x[2*CW-1:CW];
      wy_r <= (dy_r[CW] || dy_r == '0) ? '0 : prod_y[2*CW-1:CW];
    end
  end

endmodule
`default_nettype wire

@@ src/gdsc_back.sv @@
`default_nettype none
`include "grid_density_splat_counter_assert.svh"
module gdsc_back #(
  parameter int GRID_MAX   = gdsc_pkg::GRID_MAX_DEF,
  parameter int COUNT_BITS = gdsc_pkg::COUNT_BITS_DEF,
  parameter int IDX_W      = $clog2(GRID_MAX),
  parameter int ENT_W      = 4 + 2 * IDX_W + 2 * gdsc_pkg::RD_IDX_W
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  q_empty,
  input  wire logic [ENT_W-1:0]                      q_data,
  output logic                                       q_pop,
  output logic                                       clearing,
  output logic                                       out_strobe,
  output logic [gdsc_pkg::RD_IDX_W-1:0]              out_bin_col,
  output logic [gdsc_pkg::RD_IDX_W-1:0]              out_bin_row,
  output logic [gdsc_pkg::OUT_CNT_W-1:0]             out_cell_count
);

  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = gdsc_pkg::RD_IDX_W;

  gdsc_pkg::back_state_t state_r, state_nxt;

  logic [ENT_W-1:0]      ent_r;
  logic [1:0]            k_r;
  logic [AW-1:0]         clr_addr_r;
  logic [COUNT_BITS-1:0] base_cnt_r;

  logic                  e_cmd, e_oob, e_right, e_up;
  logic [IDX_W-1:0]      e_col, e_row, col_k, row_k;
  logic                  cell_en;
  logic [AW-1:0]         cell_addr;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, new_cnt;

  // entry fields
  assign e_cmd   = ent_r[ENT_W-1];
  assign e_oob   = ent_r[ENT_W-2];
  assign e_right = ent_r[ENT_W-3];
  assign e_up    = ent_r[ENT_W-4];
  assign e_col   = ent_r[2*RW+2*IDX_W-1 -: IDX_W];
  assign e_row   = ent_r[2*RW+IDX_W-1 -: IDX_W];

  // cell k of the 2x2 splat: bit 0 steps x, bit 1 steps y
  assign col_k     = e_col + IDX_W'(k_r[0]);
  assign row_k     = e_row + IDX_W'(k_r[1]);
  assign cell_addr = AW'(row_k) * AW'(GRID_MAX) + AW'(col_k);

  always_comb begin
    if (e_cmd == gdsc_pkg::CMD_READ) begin
      cell_en = (k_r == 2'd0);
    end else begin
      case (k_r)
        2'd0:    cell_en = 1'b1;
        2'd1:    cell_en = e_right;
        2'd2:    cell_en = e_up;
        2'd3:    cell_en = e_right && e_up;
        default: cell_en = 1'b0;
      endcase
    end
  end

  // saturating increment
  assign new_cnt = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdsc_pkg::B_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = gdsc_pkg::B_IDLE;
        end
      end
      gdsc_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_nxt = gdsc_pkg::B_RD;
        end
      end
      gdsc_pkg::B_RD: begin
        if (cell_en) begin
          state_nxt = gdsc_pkg::B_WR;
        end else if (k_r == 2'd3) begin
          state_nxt = gdsc_pkg::B_OUT;
        end
      end
      gdsc_pkg::B_WR: begin
        if (e_cmd == gdsc_pkg::CMD_READ || k_r == 2'd3) begin
          state_nxt = gdsc_pkg::B_OUT;
        end else begin
          state_nxt = gdsc_pkg::B_RD;
        end
      end
      gdsc_pkg::B_OUT: state_nxt = gdsc_pkg::B_IDLE;
      default:         state_nxt = gdsc_pkg::B_IDLE;
    endcase
  end

  // outputs and RAM control
  always_comb begin
    clearing   = (state_r == gdsc_pkg::B_CLEAR);
    q_pop      = (state_r == gdsc_pkg::B_IDLE) && !q_empty;
    out_strobe = (state_r == gdsc_pkg::B_OUT);
    ram_we     = clearing ||
                 ((state_r == gdsc_pkg::B_WR) && (e_cmd == gdsc_pkg::CMD_ADD));
    ram_addr   = clearing ? clr_addr_r : cell_addr;
    ram_wdata  = clearing ? '0 : new_cnt;
  end

  assign out_bin_col    = ent_r[2*RW-1 -: RW];
  assign out_bin_row    = ent_r[RW-1:0];
  assign out_cell_count = gdsc_pkg::OUT_CNT_W'(base_cnt_r);

  gdsc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gdsc_pkg::B_CLEAR;
      clr_addr_r <= '0;
      k_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (q_pop) begin
        k_r <= '0;
      end else if (state_r == gdsc_pkg::B_RD && !cell_en && k_r != 2'd3) begin
        k_r <= k_r + 2'd1;
      end else if (state_r == gdsc_pkg::B_WR && e_cmd == gdsc_pkg::CMD_ADD &&
                   k_r != 2'd3) begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
    end
    if (state_r == gdsc_pkg::B_WR) begin
      if (e_cmd == gdsc_pkg::CMD_READ) begin
        base_cnt_r <= e_oob ? '0 : ram_rdata;
      end else if (k_r == 2'd0) begin
        base_cnt_r <= new_cnt;
      end
    end
  end

  // checks
  `GDSC_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held over one cycle")
  `GDSC_ASSERT_IMPL(a_wr_after_rd, state_r == gdsc_pkg::B_WR, $past(state_r) == gdsc_pkg::B_RD, "update without a preceding read")
  `GDSC_ASSERT_IMPL(a_inc_nonzero, ram_we && !clearing, ram_wdata != '0, "count update wrote zero")
  `GDSC_ASSERT_IMPL(a_no_pop_clear, clearing, !q_pop, "queue popped during clearing pass")

endmodule
`default_nettype wire

@@ src/grid_density_splat_counter.sv @@
// Flow: a read is queued directly; an add first goes through the SUB and MUL states.
// Each cell update is a read then a write of the single-port count RAM (RD, WR),
// so the back end handles a read as one cell and an add as 1 to 4 cells.
// A two-beat queue lets the front end take the next command meanwhile.
// Reset: registers return to defaults and the count RAM is swept to zero, all
// GRID_MAX*GRID_MAX cells (4096 by default), with busy high.
`default_nettype none
module grid_density_splat_counter #(
  parameter int GRID_MAX   = gdsc_pkg::GRID_MAX_DEF,
  parameter int COUNT_BITS = gdsc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_command,
  input  wire logic signed [gdsc_pkg::COORD_W-1:0]  in_point_x,
  input  wire logic signed [gdsc_pkg::COORD_W-1:0]  in_point_y,
  input  wire logic [gdsc_pkg::RD_IDX_W-1:0]        in_read_col,
  input  wire logic [gdsc_pkg::RD_IDX_W-1:0]        in_read_row,
  // result channel
  output logic                                      out_strobe,
  output logic [gdsc_pkg::RD_IDX_W-1:0]             out_bin_col,
  output logic [gdsc_pkg::RD_IDX_W-1:0]             out_bin_row,
  output logic [gdsc_pkg::OUT_CNT_W-1:0]            out_cell_count,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [gdsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gdsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int IDX_W = $clog2(GRID_MAX);
  localparam int ENT_W = 4 + 2 * IDX_W + 2 * gdsc_pkg::RD_IDX_W;

  gdsc_pkg::cfg_t cfg_r, cfg_nxt;

  logic             front_busy, clearing, accept;
  logic             q_push, q_pop, q_full, q_empty;
  logic [ENT_W-1:0] q_wdata, q_rdata;

  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gdsc_pkg::REG_ORIGIN_X: cfg_nxt.origin_x        = cfg_wdata;
        gdsc_pkg::REG_ORIGIN_Y: cfg_nxt.origin_y        = cfg_wdata;
        gdsc_pkg::REG_BPU_X:    cfg_nxt.bins_per_unit_x = cfg_wdata;
        gdsc_pkg::REG_BPU_Y:    cfg_nxt.bins_per_unit_y = cfg_wdata;
        gdsc_pkg::REG_WIDTH:    cfg_nxt.grid_width  = cfg_wdata[gdsc_pkg::SIZE_REG_W-1:0];
        gdsc_pkg::REG_HEIGHT:   cfg_nxt.grid_height = cfg_wdata[gdsc_pkg::SIZE_REG_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x        <= '0;
      cfg_r.origin_y        <= '0;
      cfg_r.bins_per_unit_x <= 32'd65536;
      cfg_r.bins_per_unit_y <= 32'd65536;
      cfg_r.grid_width      <= 7'd64;
      cfg_r.grid_height     <= 7'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // bin computation
  gdsc_front #(
    .GRID_MAX (GRID_MAX),
    .IDX_W    (IDX_W),
    .ENT_W    (ENT_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .in_command  (in_command),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_read_col (in_read_col),
    .in_read_row (in_read_row),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .front_busy  (front_busy)
  );

  // decoupling queue
  gdsc_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (gdsc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_wdata),
    .pop   (q_pop),
    .dout  (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // count store updates
  gdsc_back #(
    .GRID_MAX   (GRID_MAX),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_strobe     (out_strobe),
    .out_bin_col    (out_bin_col),
    .out_bin_row    (out_bin_row),
    .out_cell_count (out_cell_count)
  );

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int GRID = gdsc_pkg::GRID_MAX_DEF;
  localparam int unsigned CNT_MAX = (1 << gdsc_pkg::COUNT_BITS_DEF) - 1;
  localparam int unsigned LIMIT = 200_000;
  // indexes with no register behind them; writes there must be ignored
  localparam logic [gdsc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [gdsc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic                                cmd;
    logic signed [gdsc_pkg::COORD_W-1:0] px;
    logic signed [gdsc_pkg::COORD_W-1:0] py;
    logic [gdsc_pkg::RD_IDX_W-1:0]       rc;
    logic [gdsc_pkg::RD_IDX_W-1:0]       rr;
  } cmd_beat_t;

  typedef struct packed {
    logic [gdsc_pkg::RD_IDX_W-1:0]  col;
    logic [gdsc_pkg::RD_IDX_W-1:0]  row;
    logic [gdsc_pkg::OUT_CNT_W-1:0] count;
  } bin_beat_t;

  typedef struct packed {
    logic                            is_cfg;
    logic [gdsc_pkg::CFG_IDX_W-1:0]  idx;
    logic [gdsc_pkg::CFG_DATA_W-1:0] val;
    cmd_beat_t                       beat;
    logic                            typed;
    bin_beat_t                       want;
  } plan_row_t;

  typedef struct packed {
    logic [gdsc_pkg::CFG_DATA_W-1:0] ox;
    logic [gdsc_pkg::CFG_DATA_W-1:0] oy;
    logic [gdsc_pkg::CFG_DATA_W-1:0] bx;
    logic [gdsc_pkg::CFG_DATA_W-1:0] by;
    logic [gdsc_pkg::CFG_DATA_W-1:0] w;
    logic [gdsc_pkg::CFG_DATA_W-1:0] h;
    logic [31:0]                     n;
    logic [7:0]                      reads;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = gdsc_pkg::CMD_ADD;
  logic signed [gdsc_pkg::COORD_W-1:0] in_point_x = '0;
  logic signed [gdsc_pkg::COORD_W-1:0] in_point_y = '0;
  logic [gdsc_pkg::RD_IDX_W-1:0] in_read_col = '0;
  logic [gdsc_pkg::RD_IDX_W-1:0] in_read_row = '0;
  logic out_strobe;
  logic [gdsc_pkg::RD_IDX_W-1:0] out_bin_col;
  logic [gdsc_pkg::RD_IDX_W-1:0] out_bin_row;
  logic [gdsc_pkg::OUT_CNT_W-1:0] out_cell_count;
  logic cfg_we = 1'b0;
  logic [gdsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gdsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  grid_density_splat_counter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_read_col   (in_read_col),
    .in_read_row   (in_read_row),
    .out_strobe    (out_strobe),
    .out_bin_col   (out_bin_col),
    .out_bin_row   (out_bin_row),
    .out_cell_count(out_cell_count),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the grid registers and the count store
  logic signed [gdsc_pkg::COORD_W-1:0] org_x = '0;
  logic signed [gdsc_pkg::COORD_W-1:0] org_y = '0;
  logic [gdsc_pkg::COORD_W-1:0] bpu_x = 32'h0001_0000;
  logic [gdsc_pkg::COORD_W-1:0] bpu_y = 32'h0001_0000;
  logic [gdsc_pkg::SIZE_REG_W-1:0] size_w = 7'd64;
  logic [gdsc_pkg::SIZE_REG_W-1:0] size_h = 7'd64;
  int unsigned shadow_counts [GRID*GRID];

  bin_beat_t bins_due[$];
  plan_row_t plan[$];
  setting_t settings[$];
  int unsigned read_share = 30;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // size register as the block uses it: 0 acts as 1, above GRID acts as GRID
  function automatic int unsigned active_span(logic [gdsc_pkg::SIZE_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > GRID) return GRID;
    return r;
  endfunction

  // (coord - origin) * recip, integer part of the Q32.32 product, clamped
  function automatic int unsigned axis_bin(logic signed [gdsc_pkg::COORD_W-1:0] coord,
                                           logic signed [gdsc_pkg::COORD_W-1:0] origin,
                                           logic [gdsc_pkg::COORD_W-1:0] recip,
                                           int unsigned span);
    longint diff;
    logic [63:0] mag;
    logic [63:0] prod;
    diff = longint'(coord) - longint'(origin);
    if (diff <= 0) return 0;
    mag = diff;
    prod = mag * {32'd0, recip};
    if (prod[63:32] >= span) return span - 1;
    return prod[63:32];
  endfunction

  // bin the point, splat the 2x2 block, or read one cell
  function automatic bin_beat_t predict_bin(cmd_beat_t b);
    int unsigned w, h, c, r, slot;
    bin_beat_t res;
    w = active_span(size_w);
    h = active_span(size_h);
    if (b.cmd == gdsc_pkg::CMD_READ) begin
      c = b.rc;
      r = b.rr;
    end else begin
      c = axis_bin(b.px, org_x, bpu_x, w);
      r = axis_bin(b.py, org_y, bpu_y, h);
      for (int dx = 0; dx < 2; dx++) begin
        for (int dy = 0; dy < 2; dy++) begin
          if (c + dx < w && r + dy < h) begin
            slot = (r + dy) * GRID + c + dx;
            if (shadow_counts[slot] < CNT_MAX) shadow_counts[slot]++;
          end
        end
      end
    end
    res.col = gdsc_pkg::RD_IDX_W'(c);
    res.row = gdsc_pkg::RD_IDX_W'(r);
    res.count = (c < GRID && r < GRID) ?
                gdsc_pkg::OUT_CNT_W'(shadow_counts[r * GRID + c]) : '0;
    return res;
  endfunction

  // coordinate that lands a little below, inside or just past the grid
  function automatic logic [gdsc_pkg::COORD_W-1:0] aim_coord(
      logic signed [gdsc_pkg::COORD_W-1:0] origin,
      logic [gdsc_pkg::COORD_W-1:0] recip,
      int unsigned span);
    logic [63:0] num;
    logic [63:0] quo;
    longint off;
    if (recip == 0 || $urandom_range(0, 7) == 0) begin
      off = -longint'($urandom_range(0, 32'h0002_0000));
    end else begin
      num = {32'($urandom_range(0, span + 1)), 32'($urandom)};
      quo = num / {32'd0, recip};
      off = quo;
    end
    return gdsc_pkg::COORD_W'(longint'(origin) + off);
  endfunction

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    b.px = $urandom;
    b.py = $urandom;
    b.rc = gdsc_pkg::RD_IDX_W'($urandom);
    b.rr = gdsc_pkg::RD_IDX_W'($urandom);
    if ($urandom_range(0, 99) < read_share) begin
      b.cmd = gdsc_pkg::CMD_READ;
      // mostly cells of the active grid, where counts build up
      if ($urandom_range(0, 3) != 0) begin
        b.rc = gdsc_pkg::RD_IDX_W'($urandom_range(0, active_span(size_w) - 1));
        b.rr = gdsc_pkg::RD_IDX_W'($urandom_range(0, active_span(size_h) - 1));
      end
    end else begin
      b.cmd = gdsc_pkg::CMD_ADD;
      if ($urandom_range(0, 9) != 0) begin
        b.px = aim_coord(org_x, bpu_x, active_span(size_w));
        b.py = aim_coord(org_y, bpu_y, active_span(size_h));
      end
    end
    return b;
  endfunction

  function automatic setting_t mk_setting(logic [31:0] ox, logic [31:0] oy,
                                          logic [31:0] bx, logic [31:0] by,
                                          logic [31:0] w, logic [31:0] h,
                                          logic [31:0] n, logic [7:0] reads);
    setting_t s;
    s.ox = ox;
    s.oy = oy;
    s.bx = bx;
    s.by = by;
    s.w = w;
    s.h = h;
    s.n = n;
    s.reads = reads;
    return s;
  endfunction

  task automatic plan_cmd(logic cmd, logic [31:0] px, logic [31:0] py,
                          logic [5:0] rc, logic [5:0] rr, logic typed,
                          logic [5:0] col, logic [5:0] row, logic [15:0] cnt);
    plan_row_t p;
    p = '0;
    p.beat.cmd = cmd;
    p.beat.px = px;
    p.beat.py = py;
    p.beat.rc = rc;
    p.beat.rr = rr;
    p.typed = typed;
    p.want.col = col;
    p.want.row = row;
    p.want.count = cnt;
    plan.push_back(p);
  endtask

  task automatic plan_cfg(logic [gdsc_pkg::CFG_IDX_W-1:0] idx,
                          logic [gdsc_pkg::CFG_DATA_W-1:0] val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.val = val;
    plan.push_back(p);
  endtask

  // present one beat, hold it until taken, then log what it should produce
  task automatic send_item(cmd_beat_t b, logic typed, bin_beat_t want);
    bin_beat_t got;
    start <= 1'b1;
    in_command <= b.cmd;
    in_point_x <= b.px;
    in_point_y <= b.py;
    in_read_col <= b.rc;
    in_read_row <= b.rr;
    do @(posedge clk); while (busy);
    got = predict_bin(b);
    bins_due.push_back(typed ? want : got);
  endtask

  task automatic idle_for(int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // no beat in flight and the back end settled
  task automatic quiesce();
    start <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [gdsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [gdsc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      gdsc_pkg::REG_ORIGIN_X: org_x = val;
      gdsc_pkg::REG_ORIGIN_Y: org_y = val;
      gdsc_pkg::REG_BPU_X:    bpu_x = val;
      gdsc_pkg::REG_BPU_Y:    bpu_y = val;
      gdsc_pkg::REG_WIDTH:    size_w = val[gdsc_pkg::SIZE_REG_W-1:0];
      gdsc_pkg::REG_HEIGHT:   size_h = val[gdsc_pkg::SIZE_REG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_setting(setting_t s);
    quiesce();
    write_reg(gdsc_pkg::REG_ORIGIN_X, s.ox);
    write_reg(gdsc_pkg::REG_ORIGIN_Y, s.oy);
    write_reg(gdsc_pkg::REG_BPU_X, s.bx);
    write_reg(gdsc_pkg::REG_BPU_Y, s.by);
    write_reg(gdsc_pkg::REG_WIDTH, s.w);
    write_reg(gdsc_pkg::REG_HEIGHT, s.h);
    cfg_we <= 1'b0;
    read_share = s.reads;
  endtask

  // random beats in bursts; some bursts long enough to run without gaps
  task automatic stream_points(int unsigned n);
    int unsigned left;
    left = 0;
    repeat (n) begin
      if (left == 0) begin
        left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        idle_for($urandom_range(0, 7));
      end
      left--;
      send_item(random_beat(), 1'b0, '0);
    end
  endtask

  // result checker: each strobe pops the oldest expectation, or counts a mismatch if none is due
  always @(posedge clk) begin
    bin_beat_t want;
    if (rst_n && out_strobe) begin
      if (bins_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t: unexpected result col %0d row %0d count %0d", $time,
                   out_bin_col, out_bin_row, out_cell_count);
      end else begin
        want = bins_due.pop_front();
        if (out_bin_col !== want.col || out_bin_row !== want.row ||
            out_cell_count !== want.count) begin
          mismatches++;
          // cap the log; the count still decides the verdict
          if (mismatches <= 20)
            $display("%0t: mismatch expected col %0d row %0d count %0d, got col %0d row %0d count %0d",
                     $time, want.col, want.row, want.count,
                     out_bin_col, out_bin_row, out_cell_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic prev_cfg;

    // directed beats, defaults: origin 0, one bin per unit, 64 x 64
    plan_cmd(gdsc_pkg::CMD_READ, 32'h0, 32'h0, 6'd0, 6'd0, 1'b1, 6'd0, 6'd0, 16'd0);
    plan_cmd(gdsc_pkg::CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63, 1'b1,
             6'd63, 6'd63, 16'd0);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h0002_8000, 32'h0003_0000, 6'd0, 6'd0, 1'b1,
             6'd2, 6'd3, 16'd1);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h0002_8000, 32'h0003_0000, 6'd63, 6'd63, 1'b1,
             6'd2, 6'd3, 16'd2);
    plan_cmd(gdsc_pkg::CMD_READ, 32'h0, 32'h0, 6'd3, 6'd4, 1'b1, 6'd3, 6'd4, 16'd2);
    // below the origin on both axes
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 6'd0, 6'd0, 1'b1,
             6'd0, 6'd0, 16'd1);
    // far past the grid: only the corner cell is in range
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0, 6'd0, 1'b1,
             6'd63, 6'd63, 16'd1);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h003F_0000, 32'h0, 6'd0, 6'd0, 1'b1,
             6'd63, 6'd0, 16'd1);
    plan_cmd(gdsc_pkg::CMD_READ, 32'h0, 32'h0, 6'd63, 6'd1, 1'b1, 6'd63, 6'd1, 16'd1);
    // zero sizes act as a 1 x 1 grid
    plan_cfg(gdsc_pkg::REG_WIDTH, 32'd0);
    plan_cfg(gdsc_pkg::REG_HEIGHT, 32'd0);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h0010_0000, 32'h0010_0000, 6'd0, 6'd0, 1'b1,
             6'd0, 6'd0, 16'd2);
    // oversized grid acts as full size
    plan_cfg(gdsc_pkg::REG_WIDTH, 32'h7F);
    plan_cfg(gdsc_pkg::REG_HEIGHT, 32'd65);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h0, 6'd21, 6'd42, 1'b0, '0, '0, '0);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h003E_8000, 32'h003E_8000, 6'd0, 6'd0, 1'b0, '0, '0, '0);
    // zero reciprocal folds every point into bin 0
    plan_cfg(gdsc_pkg::REG_BPU_X, 32'd0);
    plan_cfg(gdsc_pkg::REG_BPU_Y, 32'd0);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h1234_5678, 32'h7FFF_0000, 6'd0, 6'd0, 1'b0, '0, '0, '0);
    plan_cfg(gdsc_pkg::REG_BPU_X, 32'hFFFF_FFFF);
    plan_cfg(gdsc_pkg::REG_BPU_Y, 32'hFFFF_FFFF);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'd1, 32'd1, 6'd0, 6'd0, 1'b0, '0, '0, '0);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'd2, 32'd2, 6'd0, 6'd0, 1'b0, '0, '0, '0);
    plan_cfg(gdsc_pkg::REG_ORIGIN_X, 32'h8000_0000);
    plan_cfg(gdsc_pkg::REG_ORIGIN_Y, 32'h7FFF_FFFF);
    plan_cfg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
    plan_cfg(REG_UNMAPPED_HI, 32'h5A5A_5A5A);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0, 6'd0, 1'b0, '0, '0, '0);
    plan_cmd(gdsc_pkg::CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 6'd0, 6'd0, 1'b0, '0, '0, '0);
    plan_cmd(gdsc_pkg::CMD_READ, 32'h0, 32'h0, 6'd0, 6'd0, 1'b0, '0, '0, '0);
    plan_cmd(gdsc_pkg::CMD_READ, 32'h0, 32'h0, 6'd63, 6'd0, 1'b0, '0, '0, '0);
    plan_cmd(gdsc_pkg::CMD_READ, 32'h0, 32'h0, 6'd62, 6'd62, 1'b0, '0, '0, '0);

    // random phases, one grid setting each
    settings.push_back(mk_setting(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                                  32'd64, 32'd64, 32'd320, 8'd30));
    settings.push_back(mk_setting(32'hFFF6_0000, 32'h0005_8000, 32'h0004_0000,
                                  32'h0000_8000, 32'd17, 32'd9, 32'd320, 8'd30));
    settings.push_back(mk_setting($urandom, $urandom, $urandom_range(32'h800, 32'h20_0000),
                                  $urandom_range(32'h800, 32'h20_0000),
                                  $urandom_range(1, 64), $urandom_range(1, 64),
                                  32'd320, 8'd30));
    settings.push_back(mk_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1,
                                  32'd1, 32'd64, 32'd260, 8'd30));
    // junk above the size field must be dropped: 0 -> 1 wide, 127 -> full height
    settings.push_back(mk_setting($urandom, $urandom, $urandom_range(32'h800, 32'h20_0000),
                                  $urandom_range(32'h800, 32'h20_0000),
                                  32'hFFFF_FF80, 32'hABCD_EF7F, 32'd300, 8'd30));
    // 1 x 1 grid: every add lands on one cell
    settings.push_back(mk_setting(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                                  32'd1, 32'd1, 32'd10, 8'd1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) quiesce();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        send_item(plan[i].beat, plan[i].typed, plan[i].want);
      end
      prev_cfg = plan[i].is_cfg;
    end

    foreach (settings[i]) begin
      load_setting(settings[i]);
      stream_points(settings[i].n);
    end

    quiesce();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/gdsc_pkg.sv
src/gdsc_ram.sv
src/gdsc_fifo.sv
src/gdsc_front.sv
src/gdsc_back.sv
src/grid_density_splat_counter.sv
dv/tb.sv
